// ===== src/error_diffusion_dither_1bit_macros.svh =====
// Assertion macros for the error diffusion dither block.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef ERROR_DIFFUSION_DITHER_1BIT_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_1BIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDD_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be true outside reset.
`define EDD_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== src/edd_pkg.sv =====
// Shared types, constants and arithmetic helpers of the error diffusion dither.
// No dependencies.
package edd_pkg;

  localparam int EDD_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int ERRW = 20;
  localparam int RESW = 21;
  localparam int COLW = 10;
  localparam int ROWW = 12;
  localparam int IWW  = 11;
  localparam int IHW  = 13;
  localparam int CFGW = 13;
  localparam int OCW  = 11;
  localparam int ORW  = 13;
  localparam int LUMW = 16;

  localparam logic [IWW-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [IHW-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [ROWW-1:0] LAST_ROW_MAX = 12'(MAX_HEIGHT - 1);

  localparam logic [15:0] K_RED   = 16'd19595;
  localparam logic [15:0] K_GREEN = 16'd38470;
  localparam logic [15:0] K_BLUE  = 16'd7471;

  localparam logic signed [23:0] THRESH_Q8 = 24'sd32768;
  localparam logic signed [23:0] WHITE_Q8  = 24'sd65280;

  typedef logic signed [ERRW-1:0] err_t;
  typedef logic signed [RESW-1:0] res_t;

  localparam err_t ERR_MAX = 20'sh7FFFF;
  localparam err_t ERR_MIN = 20'sh80000;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic            white;
    logic [COLW-1:0] col;
    logic [ROWW-1:0] row;
    logic            last_col;
    logic            last_row;
  } pix_t;

  function automatic err_t sat20(input logic signed [23:0] v);
    if (v > 24'sd524287) begin
      return ERR_MAX;
    end else if (v < -24'sd524288) begin
      return ERR_MIN;
    end
    return err_t'(v[ERRW-1:0]);
  endfunction

  function automatic logic [LUMW-1:0] luma_q8(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    logic [23:0] sum;
    sum = 24'(r) * 24'(K_RED) + 24'(g) * 24'(K_GREEN) + 24'(b) * 24'(K_BLUE);
    return sum[23:8];
  endfunction

endpackage

// ===== src/edd_line_mem.sv =====
// Line store of error gathered for the next row: one write and one read port.
// Read data is registered and bypassed from a write to the same entry. Uses edd_pkg.
module edd_line_mem #(
  parameter int DEPTH = edd_pkg::EDD_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  edd_pkg::err_t            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output edd_pkg::err_t            rdata
);
  import edd_pkg::*;

  err_t mem [DEPTH];
  err_t rd_q;
  err_t fwd_data;
  logic fwd_hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_q     <= mem[raddr];
      fwd_hit  <= we && (waddr == raddr);
      fwd_data <= wdata;
    end
  end

  assign rdata = fwd_hit ? fwd_data : rd_q;

endmodule

// ===== src/edd_out_buf.sv =====
// Output buffer: holds one finished pixel and sends its four 2x2 requests.
// Uses edd_pkg for the pixel record.
module edd_out_buf (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  edd_pkg::pix_t            pix,
  output logic                     free,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     white,
  output logic [edd_pkg::OCW-1:0]  out_col,
  output logic [edd_pkg::ORW-1:0]  out_row,
  output logic                     last_of_pixel,
  output logic                     end_of_frame
);
  import edd_pkg::*;

  logic       valid;
  logic [1:0] cnt;
  pix_t       held;
  logic       take;
  logic       last;

  assign take = valid && !result_stall;
  assign last = (cnt == 2'd3);
  assign free = !valid || (last && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      cnt   <= 2'd0;
    end else if (take) begin
      if (last) begin
        valid <= 1'b0;
      end
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= pix;
    end
  end

  assign result_valid  = valid;
  assign white         = held.white;
  assign out_col       = {held.col, cnt[0]};
  assign out_row       = {held.row, cnt[1]};
  assign last_of_pixel = last;
  assign end_of_frame  = last && held.last_col && held.last_row;

endmodule

// ===== src/error_diffusion_dither_1bit.sv =====
// Top level of the 1-bit error diffusion dither with 2x2 output replication.
// Uses edd_pkg, edd_line_mem, edd_out_buf and the assertion macro header.
//
// Pixels (red, green, blue) enter on a valid/stall channel in raster order.
// Each pixel leaves as four requests on the result channel, in the order
// top-left, top-right, bottom-left, bottom-right of its 2x2 block, with
// last_of_pixel on the fourth and end_of_frame on the fourth of the image's
// last pixel. image_width and image_height are set on the write port; the
// user is to write them only while the block is idle, which the block
// itself leaves unchecked; out-of-range values are clamped. A pixel computes
// its luma, reads the line store when it enters the error stage, then
// commits its shares from stage 3 once the output buffer is free. Its first
// request is shown from the output buffer, after stages 1, 2 and 3. The
// result channel moves one request per cycle while result_stall is low; the
// error stage holds one pixel at a time across stages 2 and 3. After reset
// the line store is swept to zero, one entry per cycle; pixel_stall is held
// high until it is done. When the receiver stalls, the held request stays,
// up to three pixels wait in the pipeline, and then pixel_stall rises.
`include "error_diffusion_dither_1bit_macros.svh"

module error_diffusion_dither_1bit #(
  parameter int MAX_WIDTH = edd_pkg::EDD_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  edd_pkg::cfg_reg_t        cfg_index,
  input  logic [edd_pkg::CFGW-1:0] cfg_data,
  input  logic                     pixel_valid,
  output logic                     pixel_stall,
  input  logic [7:0]               red,
  input  logic [7:0]               green,
  input  logic [7:0]               blue,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     white,
  output logic [edd_pkg::OCW-1:0]  out_col,
  output logic [edd_pkg::ORW-1:0]  out_row,
  output logic                     last_of_pixel,
  output logic                     end_of_frame
);
  import edd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [AW-1:0] LAST_COL_MAX = AW'(MAX_WIDTH - 1);

  logic [IWW-1:0]  image_width;
  logic [IHW-1:0]  image_height;
  logic [AW-1:0]   last_col_idx;
  logic [ROWW-1:0] last_row_idx;

  logic [AW-1:0]   col_cnt;
  logic [ROWW-1:0] row_cnt;
  logic [AW-1:0]   cur_x;
  logic [ROWW-1:0] cur_y;
  logic            cur_lc;
  logic            cur_lr;

  logic            clr_active;
  logic [AW-1:0]   clr_idx;

  logic            s1_valid;
  logic [7:0]      s1_red;
  logic [7:0]      s1_green;
  logic [7:0]      s1_blue;
  logic [AW-1:0]   s1_x;
  logic [ROWW-1:0] s1_y;
  logic            s1_lc;
  logic            s1_lr;

  logic            s2_valid;
  logic [LUMW-1:0] s2_luma;
  logic [AW-1:0]   s2_x;
  logic [ROWW-1:0] s2_y;
  logic            s2_lc;
  logic            s2_lr;

  logic            s3_valid;
  res_t            s3_res;
  logic            s3_white;
  logic [AW-1:0]   s3_x;
  logic [ROWW-1:0] s3_y;
  logic            s3_lc;
  logic            s3_lr;

  err_t            carry_right;
  err_t            pending_below_left;
  err_t            pending_below;

  logic            dq_valid;
  logic [AW-1:0]   dq_addr;
  err_t            dq_data;

  logic            accept;
  logic            s1_free;
  logic            s2_enter;
  logic            commit;
  logic            ob_free;
  pix_t            ob_pix;

  err_t            mem_rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  err_t            mem_wdata;

  err_t              above;
  err_t              acc;
  logic signed [23:0] err_sum;
  logic signed [23:0] err_res;
  logic              is_white;

  logic signed [23:0] share7;
  logic signed [23:0] share5;
  logic signed [23:0] share3;
  logic signed [23:0] share1;
  err_t              left_data;
  err_t              below_left_next;
  logic              we_left;
  logic              we_here;
  logic              defer_here;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IWW-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      last_col_idx = '0;
    end else if (int'(image_width) > MAX_WIDTH) begin
      last_col_idx = LAST_COL_MAX;
    end else begin
      last_col_idx = AW'(image_width - 11'd1);
    end
    if (image_height == '0) begin
      last_row_idx = '0;
    end else if (int'(image_height) > MAX_HEIGHT) begin
      last_row_idx = LAST_ROW_MAX;
    end else begin
      last_row_idx = ROWW'(image_height - 13'd1);
    end
  end

  assign cur_lc = (col_cnt >= last_col_idx);
  assign cur_lr = (row_cnt >= last_row_idx);
  assign cur_x  = cur_lc ? last_col_idx : col_cnt;
  assign cur_y  = cur_lr ? last_row_idx : row_cnt;

  // Pipeline control.
  assign commit   = s3_valid && ob_free;
  assign s2_enter = s1_valid && !s2_valid && (!s3_valid || commit);
  assign s1_free  = !s1_valid || s2_enter;
  assign accept   = pixel_valid && !pixel_stall;
  assign pixel_stall = clr_active || !s1_free;

  // Line store clearing sweep after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      if (clr_idx == LAST_COL_MAX) begin
        clr_active <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Position counters advance as each pixel is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (cur_lc) begin
        col_cnt <= '0;
        row_cnt <= cur_lr ? '0 : cur_y + 1'b1;
      end else begin
        col_cnt <= cur_x + 1'b1;
        row_cnt <= cur_y;
      end
    end
  end

  // Stage 1: input registers; luma is formed during this stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s2_enter) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red   <= red;
      s1_green <= green;
      s1_blue  <= blue;
      s1_x     <= cur_x;
      s1_y     <= cur_y;
      s1_lc    <= cur_lc;
      s1_lr    <= cur_lr;
    end
  end

  // Stage 2: line store data arrives; error and threshold.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s2_enter;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_enter) begin
      s2_luma <= luma_q8(s1_red, s1_green, s1_blue);
      s2_x    <= s1_x;
      s2_y    <= s1_y;
      s2_lc   <= s1_lc;
      s2_lr   <= s1_lr;
    end
  end

  assign above    = (s2_y == '0) ? '0 : mem_rdata;
  assign acc      = sat20(24'(above) + 24'(carry_right));
  assign err_sum  = $signed(24'(s2_luma)) + 24'(acc);
  assign is_white = (err_sum >= THRESH_Q8);
  assign err_res  = is_white ? err_sum - WHITE_Q8 : err_sum;

  // Stage 3: shares are spread and the pixel is handed to the output buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_valid) begin
      s3_valid <= 1'b1;
    end else if (commit) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3_res   <= RESW'(err_res);
      s3_white <= is_white;
      s3_x     <= s2_x;
      s3_y     <= s2_y;
      s3_lc    <= s2_lc;
      s3_lr    <= s2_lr;
    end
  end

  assign share7 = (24'(s3_res) * 24'sd7) >>> 4;
  assign share5 = (24'(s3_res) * 24'sd5) >>> 4;
  assign share3 = (24'(s3_res) * 24'sd3) >>> 4;
  assign share1 = 24'(s3_res) >>> 4;

  assign left_data       = sat20(24'(pending_below_left) + share3);
  assign below_left_next = sat20(24'(pending_below) + share5);

  assign we_left    = commit && !s3_lr && (s3_x != '0);
  assign we_here    = commit && !s3_lr && s3_lc && (s3_x == '0);
  assign defer_here = commit && !s3_lr && s3_lc && (s3_x != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_right        <= '0;
      pending_below_left <= '0;
      pending_below      <= '0;
    end else if (commit) begin
      carry_right        <= s3_lc ? '0 : sat20(share7);
      pending_below_left <= (s3_lc || s3_lr) ? '0 : below_left_next;
      pending_below      <= (s3_lc || s3_lr) ? '0 : sat20(share1);
    end
  end

  // The end-of-row entry is written in the cycle after the left neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      dq_valid <= 1'b0;
    end else begin
      dq_valid <= defer_here;
    end
  end

  always_ff @(posedge clk) begin
    if (defer_here) begin
      dq_addr <= s3_x;
      dq_data <= below_left_next;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
    end else if (we_left) begin
      mem_we    = 1'b1;
      mem_waddr = s3_x - 1'b1;
      mem_wdata = left_data;
    end else if (we_here) begin
      mem_we    = 1'b1;
      mem_waddr = s3_x;
      mem_wdata = below_left_next;
    end else if (dq_valid) begin
      mem_we    = 1'b1;
      mem_waddr = dq_addr;
      mem_wdata = dq_data;
    end
  end

  edd_line_mem #(
    .DEPTH(MAX_WIDTH)
  ) u_line_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (s2_enter),
    .raddr(s1_x),
    .rdata(mem_rdata)
  );

  assign ob_pix.white    = s3_white;
  assign ob_pix.col      = COLW'(s3_x);
  assign ob_pix.row      = s3_y;
  assign ob_pix.last_col = s3_lc;
  assign ob_pix.last_row = s3_lr;

  edd_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (commit),
    .pix          (ob_pix),
    .free         (ob_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .white        (white),
    .out_col      (out_col),
    .out_row      (out_row),
    .last_of_pixel(last_of_pixel),
    .end_of_frame (end_of_frame)
  );

  `EDD_ASSERT_NEVER(a_one_in_flight, s2_valid && s3_valid, "two pixels between read and commit")
  `EDD_ASSERT_NEVER(a_wport_clash, commit && dq_valid, "commit collides with deferred write")
  `EDD_ASSERT_IMPLY(a_eof_last, result_valid && end_of_frame, last_of_pixel, "end of frame early")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for error_diffusion_dither_1bit: directed and random pixel streams are checked
// request by request against a built-in Floyd-Steinberg predictor, with random idling.
// Depends on edd_pkg and the error_diffusion_dither_1bit RTL.
module tb_top;
  import edd_pkg::*;

  typedef struct packed {
    logic        white;
    logic [10:0] col;
    logic [12:0] row;
    logic        last_of_pixel;
    logic        end_of_frame;
  } dot_write_t;

  localparam int     LINE_DEPTH      = 1024;
  localparam int     HEIGHT_CAP      = 4096;
  localparam int     WHITE_THRESHOLD = 32768;
  localparam int     WHITE_LEVEL     = 65280;
  localparam longint ERR_TOP         = 524287;
  localparam longint ERR_BOTTOM      = -524288;

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_write;
  cfg_reg_t        cfg_index;
  logic [CFGW-1:0] cfg_data;
  logic            pixel_valid;
  logic            pixel_stall;
  logic [7:0]      red;
  logic [7:0]      green;
  logic [7:0]      blue;
  logic            result_valid;
  logic            result_stall;
  logic            white;
  logic [OCW-1:0]  out_col;
  logic [ORW-1:0]  out_row;
  logic            last_of_pixel;
  logic            end_of_frame;

  bit idling_on = 1'b1;

  logic [10:0]        width_reg;
  logic [12:0]        height_reg;
  logic signed [19:0] line_err [LINE_DEPTH];
  logic signed [19:0] carry_err;
  logic signed [19:0] below_left_err;
  logic signed [19:0] below_err;
  logic [9:0]         col_pos;
  logic [11:0]        row_pos;
  dot_write_t         expected_writes [$];

  int pixels_sent    = 0;
  int writes_checked = 0;
  int frames_done    = 0;
  int mismatches     = 0;
  dot_write_t got_write;
  dot_write_t want_write;

  error_diffusion_dither_1bit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .white        (white),
    .out_col      (out_col),
    .out_row      (out_row),
    .last_of_pixel(last_of_pixel),
    .end_of_frame (end_of_frame)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [19:0] clip_err(input longint v);
    if (v > ERR_TOP) begin
      return 20'sh7FFFF;
    end
    if (v < ERR_BOTTOM) begin
      return 20'sh80000;
    end
    return v[19:0];
  endfunction

  function automatic longint share16(input longint e, input int k);
    return (e * k) >>> 4;
  endfunction

  function automatic void predict_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    int w;
    int h;
    int x;
    int y;
    bit at_last_col;
    bit at_last_row;
    bit is_white;
    longint luma;
    longint above;
    longint e;
    logic signed [19:0] acc;
    dot_write_t wr;
    w = width_reg;
    h = height_reg;
    if (w < 1) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    if (h < 1) h = 1;
    if (h > HEIGHT_CAP) h = HEIGHT_CAP;
    x = col_pos;
    y = row_pos;
    if (x >= w) x = w - 1;
    if (y >= h) y = h - 1;
    at_last_col = (x == w - 1);
    at_last_row = (y == h - 1);

    luma = (19595 * int'(r) + 38470 * int'(g) + 7471 * int'(b)) >>> 8;
    above = (y == 0) ? 0 : longint'(line_err[x]);
    acc = clip_err(above + longint'(carry_err));
    e = luma + longint'(acc);
    is_white = (e >= WHITE_THRESHOLD);
    if (is_white) e = e - WHITE_LEVEL;

    carry_err = at_last_col ? 20'sd0 : clip_err(share16(e, 7));
    if (!at_last_row) begin
      if (x > 0) line_err[x - 1] = clip_err(longint'(below_left_err) + share16(e, 3));
      below_left_err = clip_err(longint'(below_err) + share16(e, 5));
      below_err = at_last_col ? 20'sd0 : clip_err(share16(e, 1));
      if (at_last_col) begin
        line_err[x] = below_left_err;
        below_left_err = '0;
      end
    end else begin
      below_left_err = '0;
      below_err = '0;
    end

    for (int k = 0; k < 4; k++) begin
      wr.white = is_white;
      wr.col = 11'(2 * x + (k & 1));
      wr.row = 13'(2 * y + (k >> 1));
      wr.last_of_pixel = (k == 3);
      wr.end_of_frame = (k == 3) && at_last_col && at_last_row;
      expected_writes.push_back(wr);
    end

    if (at_last_col) begin
      below_left_err = '0;
      below_err = '0;
      carry_err = '0;
      col_pos = '0;
      row_pos = at_last_row ? 12'd0 : 12'(y + 1);
    end else begin
      col_pos = 10'(x + 1);
      row_pos = 12'(y);
    end
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(120, 136));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (pixel_stall);
    predict_pixel(r, g, b);
    pixels_sent++;
  endtask

  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_image_size(input logic [CFGW-1:0] w, input logic [CFGW-1:0] h);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_write <= 1'b0;
    width_reg = w[10:0];
    height_reg = h;
  endtask

  // Reset geometry is 640 by 480; the stream stays inside row 0.
  task automatic test_reset_config();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
  endtask

  // Shrinking the width mid-row ends the row at once.
  task automatic test_mid_image_change();
    set_image_size(13'd2, 13'd2);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
  endtask

  task automatic test_width_edges();
    set_image_size(13'd0, 13'd3);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
  endtask

  task automatic test_height_edges();
    set_image_size(13'd1, 13'd0);
    send_pixel(8'd200, 8'd10, 8'd90);
    send_pixel(8'd127, 8'd128, 8'd129);
    // Width bits above the register are dropped, so this is a width of 3.
    set_image_size(13'h1803, 13'h1FFF);
    repeat (4) send_pixel(pick_level(), pick_level(), pick_level());
    set_image_size(13'd3, 13'd2);
    repeat (2) send_pixel(pick_level(), pick_level(), pick_level());
    set_image_size(13'h07FF, 13'd4096);
    repeat (3) send_pixel(pick_level(), pick_level(), pick_level());
    set_image_size(13'd1, 13'd1);
    send_pixel(8'd255, 8'd255, 8'd255);
  endtask

  task automatic test_full_width();
    set_image_size(13'd1024, 13'd2);
    repeat (6) send_pixel(pick_level(), pick_level(), pick_level());
  endtask

  // Mostly whole small images; some are cut short to leave the counters mid-image.
  task automatic test_random_images(input int pixel_goal);
    int sent;
    int w;
    int h;
    int n;
    sent = 0;
    while (sent < pixel_goal) begin
      w = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
      h = $urandom_range(1, 5);
      n = w * h;
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
      set_image_size(13'(w), 13'(h));
      repeat (n) send_pixel(pick_level(), pick_level(), pick_level());
      sent += n;
    end
  endtask

  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      got_write = {white, out_col, out_row, last_of_pixel, end_of_frame};
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected request: white=%0d col=%0d row=%0d last=%0d eof=%0d",
                   white, out_col, out_row, last_of_pixel, end_of_frame);
        end
      end else begin
        want_write = expected_writes.pop_front();
        writes_checked++;
        if (got_write.end_of_frame === 1'b1) frames_done++;
        if (got_write !== want_write) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Request %0d expected white=%0d col=%0d row=%0d last=%0d eof=%0d",
                     writes_checked, want_write.white, want_write.col, want_write.row,
                     want_write.last_of_pixel, want_write.end_of_frame);
            $display("  got white=%0d col=%0d row=%0d last=%0d eof=%0d",
                     got_write.white, got_write.col, got_write.row,
                     got_write.last_of_pixel, got_write.end_of_frame);
          end
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= '0;
    pixel_valid <= 1'b0;
    red <= '0;
    green <= '0;
    blue <= '0;
    width_reg = 11'd640;
    height_reg = 13'd480;
    foreach (line_err[i]) line_err[i] = '0;
    carry_err = '0;
    below_left_err = '0;
    below_err = '0;
    col_pos = '0;
    row_pos = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_mid_image_change();
    test_width_edges();
    test_height_edges();
    test_full_width();
    test_random_images(60);
    wait_idle();
    idling_on = 1'b0;
    test_random_images(25);
    wait_idle();
    repeat (16) @(posedge clk);

    $display("Sent %0d pixels over widths 1 to 1024 and heights 1 to 4096, %0d frames ended.",
             pixels_sent, frames_done);
    $display("Checked %0d output requests with %0d mismatches.", writes_checked, mismatches);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
